[rtl/core/bba_pkg.sv]
// Shared types and codes of the buddy block allocator.
`default_nettype none

package bba_pkg;

  localparam logic       ACT_ALLOC = 1'b0;
  localparam logic       ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_DECODE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_SPLIT  = 3'd4;
  localparam logic [2:0] OP_MERGE  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       emit;
  } bba_cmd_t;

  typedef struct packed {
    logic dec_err;
    logic is_free;
    logic found;
    logic at_want;
    logic at_top;
    logic split_last;
    logic merge_stop;
  } bba_sts_t;

endpackage

`default_nettype wire

[rtl/core/bba_datapath.sv]
// Datapath of the buddy block allocator: free bitmaps, held table, search, split and merge.
`default_nettype none

module bba_datapath
  import bba_pkg::*;
#(
  parameter int MEM_BYTES    = 1024,
  parameter int MIN_BLOCK    = 32,
  parameter int TOP_ORDER    = 5,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire bba_cmd_t    cmd,
  output bba_sts_t         sts,
  input  wire logic        action,
  input  wire logic [15:0] request_bytes,
  input  wire logic [9:0]  block_offset,
  output logic [1:0]       status,
  output logic [9:0]       granted_offset,
  output logic [2:0]       granted_order
);

  localparam int SLOT_COUNT  = MEM_BYTES / MIN_BLOCK;
  localparam int ORDER_COUNT = TOP_ORDER + 1;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ORD_W       = $clog2(ORDER_COUNT);
  localparam int MB_LOG      = $clog2(MIN_BLOCK);

  logic [SLOT_COUNT-1:0] free_map [ORDER_COUNT];
  logic [SLOT_COUNT-1:0] held_flag;
  logic [ORD_W-1:0]      held_order [SLOT_COUNT];

  logic              act_r;
  logic [15:0]       bytes_r;
  logic [9:0]        off_r;
  logic [ORD_W-1:0]  want;
  logic [ORD_W-1:0]  cur;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        res_status;
  logic [9:0]        res_offset;
  logic [2:0]        res_order;

  logic [16:0]       need;
  logic              fit_any;
  logic [ORD_W-1:0]  want_calc;
  logic [31:0]       off_slot_full;
  logic [SLOT_W-1:0] off_slot;
  logic              free_err;
  logic [SLOT_COUNT-1:0] row;
  logic [31:0]       low_mask;
  logic              found;
  logic [SLOT_W-1:0] pick;
  logic              at_want;
  logic              at_top;
  logic [ORD_W-1:0]  nxt;
  logic [31:0]       half_full;
  logic              half_in;
  logic              split_last;
  logic [31:0]       bit_full;
  logic [31:0]       buddy_full;
  logic [SLOT_W-1:0] buddy_idx;
  logic              buddy_ok;
  logic [SLOT_W-1:0] slot_clr;

  function automatic logic [9:0] off_of(input logic [SLOT_W-1:0] s);
    off_of = 10'(32'(s) << MB_LOG);
  endfunction

  always_comb begin
    need      = 17'(bytes_r) + 17'(HEADER_BYTES);
    fit_any   = 1'b0;
    want_calc = '0;
    for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
      if ((32'(MIN_BLOCK) << k) >= 32'(need)) begin
        fit_any   = 1'b1;
        want_calc = ORD_W'(k);
      end
    end
  end

  assign off_slot_full = 32'(off_r) >> MB_LOG;
  assign off_slot      = off_slot_full[SLOT_W-1:0];
  assign free_err      = ((32'(off_r) & 32'(MIN_BLOCK - 1)) != 32'd0)
                         || (off_slot_full >= 32'(SLOT_COUNT))
                         || !held_flag[off_slot];

  assign row      = free_map[cur];
  assign low_mask = (32'd1 << cur) - 32'd1;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (row[s] && ((32'(s) & low_mask) == 32'd0)) begin
        found = 1'b1;
        pick  = SLOT_W'(s);
      end
    end
  end

  assign at_want    = (cur == want);
  assign at_top     = (cur == ORD_W'(TOP_ORDER));
  assign nxt        = cur - ORD_W'(1);
  assign half_full  = 32'(slot) + (32'd1 << nxt);
  assign half_in    = (half_full < 32'(SLOT_COUNT));
  assign split_last = (nxt == want);
  assign bit_full   = 32'd1 << cur;
  assign buddy_full = 32'(slot) ^ bit_full;
  assign buddy_idx  = buddy_full[SLOT_W-1:0];
  assign buddy_ok   = !at_top && (buddy_full < 32'(SLOT_COUNT)) && row[buddy_idx];
  assign slot_clr   = SLOT_W'(32'(slot) & ~bit_full);

  always_comb begin
    sts.dec_err    = (act_r == ACT_FREE) ? free_err : !fit_any;
    sts.is_free    = (act_r == ACT_FREE);
    sts.found      = found;
    sts.at_want    = at_want;
    sts.at_top     = at_top;
    sts.split_last = split_last;
    sts.merge_stop = !buddy_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < ORDER_COUNT; o++) begin
        free_map[o] <= '0;
      end
      free_map[TOP_ORDER][0] <= 1'b1;
      held_flag <= '0;
    end else begin
      unique case (cmd.op)
        OP_DECODE: begin
          if (act_r == ACT_FREE && !free_err) held_flag[off_slot] <= 1'b0;
        end
        OP_SEARCH: begin
          if (found) begin
            free_map[cur][pick] <= 1'b0;
            if (at_want) held_flag[pick] <= 1'b1;
          end
        end
        OP_SPLIT: begin
          if (half_in) free_map[nxt][half_full[SLOT_W-1:0]] <= 1'b1;
          if (split_last) held_flag[slot] <= 1'b1;
        end
        OP_MERGE: begin
          if (buddy_ok) free_map[cur][buddy_idx] <= 1'b0;
          else free_map[cur][slot] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act_r   <= action;
        bytes_r <= request_bytes;
        off_r   <= block_offset;
      end
      OP_DECODE: begin
        if (act_r == ACT_ALLOC) begin
          if (!fit_any) begin
            res_status <= ST_TOO_LARGE;
            res_offset <= '0;
            res_order  <= '0;
          end else begin
            want <= want_calc;
            cur  <= want_calc;
          end
        end else begin
          if (free_err) begin
            res_status <= ST_BAD_FREE;
            res_offset <= '0;
            res_order  <= '0;
          end else begin
            cur  <= held_order[off_slot];
            slot <= off_slot;
          end
        end
      end
      OP_SEARCH: begin
        if (found) begin
          slot <= pick;
          if (at_want) begin
            held_order[pick] <= want;
            res_status <= ST_OK;
            res_offset <= off_of(pick);
            res_order  <= 3'(cur);
          end
        end else if (at_top) begin
          res_status <= ST_NO_FREE;
          res_offset <= '0;
          res_order  <= '0;
        end else begin
          cur <= cur + ORD_W'(1);
        end
      end
      OP_SPLIT: begin
        cur <= nxt;
        if (split_last) begin
          held_order[slot] <= want;
          res_status <= ST_OK;
          res_offset <= off_of(slot);
          res_order  <= 3'(nxt);
        end
      end
      OP_MERGE: begin
        if (buddy_ok) begin
          slot <= slot_clr;
          cur  <= cur + ORD_W'(1);
        end else begin
          res_status <= ST_OK;
          res_offset <= off_of(slot);
          res_order  <= 3'(cur);
        end
      end
      default: ;
    endcase
    if (cmd.emit) begin
      status         <= res_status;
      granted_offset <= res_offset;
      granted_order  <= res_order;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bba_ctrl.sv]
// Sequencer of the buddy block allocator: steps one item through decode, search, split or merge.
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bba_cmd_t      cmd,
  input  wire bba_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_MERGE  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        if (sts.dec_err) state_next = S_EMIT;
        else if (sts.is_free) state_next = S_MERGE;
        else state_next = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.op = OP_SEARCH;
        if (sts.found) state_next = sts.at_want ? S_EMIT : S_SPLIT;
        else if (sts.at_top) state_next = S_EMIT;
      end
      S_SPLIT: begin
        cmd.op = OP_SPLIT;
        if (sts.split_last) state_next = S_EMIT;
      end
      S_MERGE: begin
        cmd.op = OP_MERGE;
        if (sts.merge_stop) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("accepted beat not followed by decode");

  a_emit_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote a pending beat");

  a_split_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> ($past(state) == S_SEARCH || $past(state) == S_SPLIT))
    else $error("split entered without a search hit");

endmodule

`default_nettype wire

[rtl/core/buddy_block_allocator.sv]
// Top level of the buddy block allocator: sequencer and datapath.
//
//  channel | signals                                          | dir
//  in      | in_valid, in_ready, action, request_bytes, block_offset | sink
//  out     | out_valid, out_ready, status, granted_offset, granted_order | source
//
// One item at a time. Allocate: accept, decode, one search step per order searched,
// one split step per split, emit. Free: accept, decode, one merge step per level merged
// plus a final one, emit. A too-large request or a bad free goes from decode straight
// to emit.
// Reset leaves only the whole-memory block free and nothing held, at once.
// A result waiting on out_ready holds the next item in the emit step.
`default_nettype none

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MEM_BYTES    = 1024,
  parameter int MIN_BLOCK    = 32,
  parameter int TOP_ORDER    = 5,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [15:0] request_bytes,
  input  wire logic [9:0]  block_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [9:0]       granted_offset,
  output logic [2:0]       granted_order
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bba_datapath #(
    .MEM_BYTES    (MEM_BYTES),
    .MIN_BLOCK    (MIN_BLOCK),
    .TOP_ORDER    (TOP_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .status         (status),
    .granted_offset (granted_offset),
    .granted_order  (granted_order)
  );

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_offset == 10'd0 && granted_order == 3'd0))
    else $error("error beat carries a block");

endmodule

`default_nettype wire

[dv/tb_buddy_block_allocator.sv]
// Self-checking testbench for the buddy block allocator: directed and random traffic.
`default_nettype none

module tb_buddy_block_allocator;

  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MEM_BYTES    = 1024;
  localparam int MIN_BLOCK    = 32;
  localparam int TOP_ORDER    = 5;
  localparam int HEADER_BYTES = 16;
  localparam int SLOTS        = MEM_BYTES / MIN_BLOCK;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 30;

  typedef struct {
    logic [1:0] status;
    logic [9:0] offset;
    logic [2:0] order;
  } grant_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        action        = ACT_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [9:0]  block_offset  = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [1:0]  status;
  logic [9:0]  granted_offset;
  logic [2:0]  granted_order;

  bit       free_map  [0:TOP_ORDER][0:SLOTS-1];
  bit [2:0] held_order[0:SLOTS-1];
  bit       held_flag [0:SLOTS-1];

  grant_t pending_grants[$];
  int     err_count     = 0;
  int     cycle_count   = 0;
  int     in_gap_max    = 12;
  int     out_stall_max = 12;

  buddy_block_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_offset (granted_offset),
    .granted_order  (granted_order)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void reset_allocation_state();
    for (int o = 0; o <= TOP_ORDER; o++) begin
      for (int s = 0; s < SLOTS; s++) begin
        free_map[o][s] = 1'b0;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      held_order[s] = '0;
      held_flag[s]  = 1'b0;
    end
    free_map[TOP_ORDER][0] = 1'b1;
  endfunction

  function automatic grant_t predict_alloc(logic [15:0] bytes);
    grant_t g;
    int     need;
    int     want;
    int     cur;
    int     slot;
    int     half;
    bit     found;
    g.status = ST_OK;
    g.offset = '0;
    g.order  = '0;
    need     = int'(bytes) + HEADER_BYTES;
    want     = 0;
    slot     = 0;
    found    = 1'b0;
    while (want <= TOP_ORDER && (MIN_BLOCK << want) < need) want++;
    if (want > TOP_ORDER) begin
      g.status = ST_TOO_LARGE;
      return g;
    end
    for (cur = want; cur <= TOP_ORDER; cur++) begin
      for (int s = 0; s < SLOTS; s += (1 << cur)) begin
        if (free_map[cur][s]) begin
          slot  = s;
          found = 1'b1;
          break;
        end
      end
      if (found) break;
    end
    if (!found) begin
      g.status = ST_NO_FREE;
      return g;
    end
    free_map[cur][slot] = 1'b0;
    while (cur > want) begin
      cur--;
      half = slot + (1 << cur);
      if (half < SLOTS) free_map[cur][half] = 1'b1;
    end
    held_flag[slot]  = 1'b1;
    held_order[slot] = 3'(want);
    g.offset = 10'(slot * MIN_BLOCK);
    g.order  = 3'(want);
    return g;
  endfunction

  function automatic grant_t predict_release(logic [9:0] off);
    grant_t g;
    int     slot;
    int     ord;
    int     buddy;
    g.status = ST_OK;
    g.offset = '0;
    g.order  = '0;
    slot     = int'(off) / MIN_BLOCK;
    if ((int'(off) % MIN_BLOCK) != 0 || slot >= SLOTS || !held_flag[slot]) begin
      g.status = ST_BAD_FREE;
      return g;
    end
    ord = int'(held_order[slot]);
    if (ord > TOP_ORDER) ord = TOP_ORDER;
    held_flag[slot]  = 1'b0;
    held_order[slot] = '0;
    while (ord < TOP_ORDER) begin
      buddy = slot ^ (1 << ord);
      if (buddy >= SLOTS || !free_map[ord][buddy]) break;
      free_map[ord][buddy] = 1'b0;
      slot = slot & ~(1 << ord);
      ord++;
    end
    free_map[ord][slot] = 1'b1;
    g.offset = 10'(slot * MIN_BLOCK);
    g.order  = 3'(ord);
    return g;
  endfunction

  task automatic send_beat(input logic act, input logic [15:0] bytes, input logic [9:0] off);
    int     gap;
    grant_t g;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    request_bytes <= bytes;
    block_offset  <= off;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ALLOC) g = predict_alloc(bytes);
    else g = predict_release(off);
    pending_grants.push_back(g);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  function automatic int pick_held_slot();
    int held[$];
    for (int s = 0; s < SLOTS; s++) begin
      if (held_flag[s]) held.push_back(s);
    end
    if (held.size() == 0) return -1;
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  function automatic int pick_order();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 65) return 1;
    if (roll < 80) return 2;
    if (roll < 90) return 3;
    if (roll < 96) return 4;
    return 5;
  endfunction

  function automatic logic [15:0] bytes_for_order(int ord);
    if (ord == 0) return 16'($urandom_range(0, MIN_BLOCK - HEADER_BYTES));
    return 16'($urandom_range((MIN_BLOCK << (ord - 1)) - HEADER_BYTES + 1,
                              (MIN_BLOCK << ord) - HEADER_BYTES));
  endfunction

  task automatic send_noise();
    int         kind;
    int         slot;
    logic [9:0] off;
    kind = $urandom_range(0, 3);
    off  = 10'($urandom);
    case (kind)
      0: begin
        send_beat(ACT_ALLOC, 16'($urandom_range(MEM_BYTES - HEADER_BYTES + 1, 65535)), off);
      end
      1: begin
        if (off[4:0] == '0) off[0] = 1'b1;
        send_beat(ACT_FREE, 16'($urandom), off);
      end
      2: begin
        slot = $urandom_range(0, SLOTS - 1);
        if (held_flag[slot]) send_beat(ACT_FREE, 16'($urandom), off | 10'd1);
        else send_beat(ACT_FREE, 16'($urandom), 10'(slot * MIN_BLOCK));
      end
      default: begin
        send_beat(1'($urandom), 16'($urandom), off);
      end
    endcase
  endtask

  task automatic send_random_item(int noise_pct);
    int slot;
    if ($urandom_range(0, 99) < noise_pct) begin
      send_noise();
    end else begin
      slot = pick_held_slot();
      if (slot >= 0 && $urandom_range(0, 99) < 45) begin
        send_beat(ACT_FREE, 16'($urandom), 10'(slot * MIN_BLOCK));
      end else begin
        send_beat(ACT_ALLOC, bytes_for_order(pick_order()), 10'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_beat(ACT_ALLOC, 16'd0, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd16, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd17, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd1008, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd1009, 10'($urandom));
    send_beat(ACT_ALLOC, 16'hFFFF, 10'($urandom));
    send_beat(ACT_FREE, 16'($urandom), 10'd1);
    send_beat(ACT_FREE, 16'($urandom), 10'h3FF);
    send_beat(ACT_FREE, 16'($urandom), 10'd992);
    send_beat(ACT_FREE, 16'($urandom), 10'd32);
    send_beat(ACT_FREE, 16'($urandom), 10'd32);
    send_beat(ACT_FREE, 16'($urandom), 10'd0);
    send_beat(ACT_FREE, 16'($urandom), 10'd64);
    send_beat(ACT_ALLOC, 16'd1008, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd0, 10'($urandom));
    send_beat(ACT_FREE, 16'($urandom), 10'd0);
    send_beat(ACT_ALLOC, 16'd496, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd497, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd400, 10'($urandom));
    send_beat(ACT_ALLOC, 16'd0, 10'($urandom));
    send_beat(ACT_FREE, 16'($urandom), 10'd512);
    send_beat(ACT_FREE, 16'($urandom), 10'd0);
  endtask

  task automatic test_full_memory();
    int slot;
    int tmp;
    int j;
    int order_list[SLOTS];
    in_gap_max    = 4;
    out_stall_max = 12;
    slot = pick_held_slot();
    while (slot >= 0) begin
      send_beat(ACT_FREE, 16'($urandom), 10'(slot * MIN_BLOCK));
      slot = pick_held_slot();
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_beat(ACT_ALLOC, bytes_for_order(0), 10'($urandom));
      order_list[i] = i;
    end
    send_beat(ACT_ALLOC, bytes_for_order(0), 10'($urandom));
    for (int i = SLOTS - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      tmp           = order_list[i];
      order_list[i] = order_list[j];
      order_list[j] = tmp;
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_beat(ACT_FREE, 16'($urandom), 10'(order_list[i] * MIN_BLOCK));
    end
    send_beat(ACT_FREE, 16'($urandom), 10'(order_list[0] * MIN_BLOCK));
  endtask

  task automatic test_random_mix(int count);
    in_gap_max    = 12;
    out_stall_max = 12;
    for (int i = 0; i < count; i++) send_random_item(15);
  endtask

  task automatic test_back_to_back(int count);
    in_gap_max    = 0;
    out_stall_max = 0;
    for (int i = 0; i < count; i++) send_random_item(15);
  endtask

  task automatic test_drain_pauses(int count);
    in_gap_max    = 12;
    out_stall_max = 3;
    for (int i = 0; i < count; i++) begin
      send_random_item(20);
      if (i % 25 == 24) wait_drained();
    end
  endtask

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int stall;
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: status %0d offset %0d order %0d",
               status, granted_offset, granted_order);
        err_count++;
      end else begin
        g = pending_grants.pop_front();
        if (status !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, status);
          err_count++;
        end
        if (granted_offset !== g.offset) begin
          $error("granted_offset: expected %0d, got %0d", g.offset, granted_offset);
          err_count++;
        end
        if (granted_order !== g.order) begin
          $error("granted_order: expected %0d, got %0d", g.order, granted_order);
          err_count++;
        end
      end
    end
  end

  initial begin
    reset_allocation_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_memory();
    test_random_mix(600);
    test_back_to_back(250);
    test_drain_pauses(300);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
